// File: sv/rsd_pkg.sv
package rsd_pkg;

  // Field widths fixed by the interface.
  localparam int FIELD_SAMPLE_WIDTH = 16;
  localparam int MERGE_COUNT_WIDTH  = 32;
  localparam int SUM_WIDTH          = 48;
  localparam int SQ_WIDTH           = 63;
  localparam int DEV_WIDTH          = 16;
  localparam int OUT_COUNT_WIDTH    = 32;

  // The squared sum is built from three half-width partial products.
  localparam int HALF_WIDTH     = SUM_WIDTH / 2;
  localparam int PROD_WIDTH     = 2 * HALF_WIDTH;
  localparam int SQUARE_WIDTH   = 2 * SUM_WIDTH;
  localparam int RADICAND_WIDTH = SQ_WIDTH + 1;
  localparam int ROOT_WIDTH     = RADICAND_WIDTH / 2;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int FILL_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_MERGE  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_REPORT = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    CMD_ACC    = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_t;

  typedef struct packed {
    req_type_t                             req_type;
    logic signed [FIELD_SAMPLE_WIDTH-1:0]  sample_value;
    logic        [MERGE_COUNT_WIDTH-1:0]   merge_count;
    logic signed [SUM_WIDTH-1:0]           merge_sum;
    logic        [SQ_WIDTH-1:0]            merge_sum_squares;
  } in_item_t;

  typedef struct packed {
    logic [DEV_WIDTH-1:0]       std_deviation;
    logic [OUT_COUNT_WIDTH-1:0] sample_count;
  } out_item_t;

  // One classified command: an add and a merge both become deltas.
  typedef struct packed {
    cmd_t                          cmd;
    logic [MERGE_COUNT_WIDTH-1:0]  cnt_delta;
    logic signed [SUM_WIDTH-1:0]   sum_delta;
    logic [SQ_WIDTH-1:0]           sq_delta;
  } q_entry_t;

endpackage

// File: sv/rsd_div.sv
module rsd_div #(
  parameter int DIVIDEND_WIDTH = 96,
  parameter int DIVISOR_WIDTH  = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DIVIDEND_WIDTH-1:0] dividend,
  input  logic [DIVISOR_WIDTH-1:0]  divisor,
  output logic [DIVIDEND_WIDTH-1:0] quotient,
  output logic                      done
);
  import rsd_pkg::*;

  localparam int CNT_WIDTH = $clog2(DIVIDEND_WIDTH);

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of work while quotient bits shift in at the bottom.
  logic [DIVIDEND_WIDTH-1:0] work;
  logic [DIVISOR_WIDTH-1:0]  rem;
  logic [DIVISOR_WIDTH-1:0]  dvsr;
  logic [CNT_WIDTH-1:0]      cnt;
  logic                      busy;

  logic [DIVISOR_WIDTH:0] trial;
  logic [DIVISOR_WIDTH:0] trial_sub;
  logic                   take;

  always_comb begin
    trial     = {rem, work[DIVIDEND_WIDTH-1]};
    trial_sub = trial - {1'b0, dvsr};
    take      = (trial >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        work <= dividend;
        rem  <= '0;
        dvsr <= divisor;
        cnt  <= CNT_WIDTH'(DIVIDEND_WIDTH - 1);
        busy <= 1'b1;
      end else if (busy) begin
        work <= {work[DIVIDEND_WIDTH-2:0], take};
        rem  <= take ? trial_sub[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_WIDTH'(1);
        end
      end
    end
  end

  assign quotient = work;

endmodule

// File: sv/rsd_sqrt.sv
module rsd_sqrt #(
  parameter int RADICAND_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [RADICAND_WIDTH-1:0]   radicand,
  output logic [RADICAND_WIDTH/2-1:0] root,
  output logic                        done
);
  import rsd_pkg::*;

  localparam int RT_WIDTH  = RADICAND_WIDTH / 2;
  localparam int CNT_WIDTH = $clog2(RT_WIDTH);

  // Digit-by-digit integer square root, one root bit per cycle.
  logic [RADICAND_WIDTH-1:0] val;
  logic [RT_WIDTH-1:0]       rt;
  logic [RT_WIDTH+1:0]       rem;
  logic [CNT_WIDTH-1:0]      cnt;
  logic                      busy;

  logic [RT_WIDTH+3:0] shifted;
  logic [RT_WIDTH+3:0] trial;
  logic [RT_WIDTH+3:0] shifted_sub;
  logic                take;

  always_comb begin
    shifted     = {rem, val[RADICAND_WIDTH-1 -: 2]};
    trial       = {2'b00, rt, 2'b01};
    shifted_sub = shifted - trial;
    take        = (shifted >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        val  <= radicand;
        rt   <= '0;
        rem  <= '0;
        cnt  <= CNT_WIDTH'(RT_WIDTH - 1);
        busy <= 1'b1;
      end else if (busy) begin
        val <= {val[RADICAND_WIDTH-3:0], 2'b00};
        rem <= take ? shifted_sub[RT_WIDTH+1:0] : shifted[RT_WIDTH+1:0];
        rt  <= {rt[RT_WIDTH-2:0], take};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_WIDTH'(1);
        end
      end
    end
  end

  assign root = rt;

endmodule

// File: sv/rsd_front.sv
module rsd_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  rsd_pkg::in_item_t req,
  output logic              head_valid,
  input  logic              head_pop,
  output rsd_pkg::q_entry_t head
);
  import rsd_pkg::*;

  localparam int MAG_SQ_WIDTH = 2 * SAMPLE_WIDTH;

  logic signed [SAMPLE_WIDTH-1:0] sample_s;
  logic        [SAMPLE_WIDTH-1:0] sample_mag;
  logic        [MAG_SQ_WIDTH-1:0] sample_sq;
  q_entry_t                       entry;

  q_entry_t             queue_mem [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wptr;
  logic [QPTR_WIDTH-1:0] rptr;
  logic [FILL_WIDTH-1:0] fill;
  logic                  push;
  logic                  pop;

  // Classify the beat: a sample and a merge both turn into deltas for the
  // three accumulators, so the back end has a single accumulate command.
  always_comb begin
    sample_s   = $signed(SAMPLE_WIDTH'($unsigned(req.sample_value)));
    sample_mag = sample_s[SAMPLE_WIDTH-1] ? $unsigned(-sample_s) : $unsigned(sample_s);
    sample_sq  = MAG_SQ_WIDTH'(sample_mag) * MAG_SQ_WIDTH'(sample_mag);
    entry      = '0;
    unique case (req.req_type)
      REQ_ADD: begin
        entry.cmd       = CMD_ACC;
        entry.cnt_delta = MERGE_COUNT_WIDTH'(1);
        entry.sum_delta = SUM_WIDTH'(sample_s);
        entry.sq_delta  = SQ_WIDTH'(sample_sq);
      end
      REQ_MERGE: begin
        entry.cmd       = CMD_ACC;
        entry.cnt_delta = req.merge_count;
        entry.sum_delta = req.merge_sum;
        entry.sq_delta  = req.merge_sum_squares;
      end
      REQ_CLEAR:  entry.cmd = CMD_CLEAR;
      REQ_REPORT: entry.cmd = CMD_REPORT;
    endcase
  end

  assign req_ready  = (fill != FILL_WIDTH'(QUEUE_DEPTH)) && !rst;
  assign head_valid = (fill != '0);
  assign head       = queue_mem[rptr];
  assign push       = req_valid && req_ready;
  assign pop        = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wptr + QPTR_WIDTH'(1);
      end
      if (pop) begin
        rptr <= (rptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rptr + QPTR_WIDTH'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_WIDTH'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_WIDTH'(1);
      end
    end
  end

endmodule

// File: sv/rsd_back.sv
module rsd_back #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  rsd_pkg::q_entry_t  head,
  output logic               head_pop,
  output logic               rpt_valid,
  input  logic               rpt_ready,
  output rsd_pkg::out_item_t rpt
);
  import rsd_pkg::*;

  localparam int CNT_EXT_WIDTH = MERGE_COUNT_WIDTH + 1;
  localparam int SUM_EXT_WIDTH = SUM_WIDTH + 1;
  localparam int SQ_EXT_WIDTH  = SQ_WIDTH + 1;
  localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX = '1;
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic [SQ_WIDTH-1:0] SQ_MAX = '1;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SQUARE  = 6'b000010,
    ST_DIV_Q   = 6'b000100,
    ST_DIV_VAR = 6'b001000,
    ST_ROOT    = 6'b010000,
    ST_HOLD    = 6'b100000
  } state_t;

  state_t state;

  logic [COUNT_WIDTH-1:0]      acc_count;
  logic signed [SUM_WIDTH-1:0] acc_sum;
  logic [SQ_WIDTH-1:0]         acc_sum_squares;

  logic [COUNT_WIDTH-1:0]      acc_count_next;
  logic signed [SUM_WIDTH-1:0] acc_sum_next;
  logic [SQ_WIDTH-1:0]         acc_sum_squares_next;

  logic [CNT_EXT_WIDTH-1:0]        cnt_total;
  logic signed [SUM_EXT_WIDTH-1:0] sum_total;
  logic [SQ_EXT_WIDTH-1:0]         sq_total;

  logic [1:0]              step;
  logic [SUM_WIDTH-1:0]    mag;
  logic [HALF_WIDTH-1:0]   mul_a;
  logic [HALF_WIDTH-1:0]   mul_b;
  logic [PROD_WIDTH-1:0]   prod;
  logic [SQUARE_WIDTH-1:0] square;
  logic [DEV_WIDTH-1:0]    result;

  logic                      div_start;
  logic [SQUARE_WIDTH-1:0]   div_dividend;
  logic [SQUARE_WIDTH-1:0]   div_quotient;
  logic                      div_done;
  logic                      quot_fits;

  logic                      sqrt_start;
  logic [RADICAND_WIDTH-1:0] sqrt_radicand;
  logic [ROOT_WIDTH-1:0]     sqrt_root;
  logic                      sqrt_done;

  // Saturating accumulate of the deltas at the head of the queue.
  always_comb begin
    cnt_total = CNT_EXT_WIDTH'(acc_count) + CNT_EXT_WIDTH'(head.cnt_delta);
    sum_total = SUM_EXT_WIDTH'(acc_sum) + SUM_EXT_WIDTH'(head.sum_delta);
    sq_total  = SQ_EXT_WIDTH'(acc_sum_squares) + SQ_EXT_WIDTH'(head.sq_delta);

    acc_count_next = (cnt_total > CNT_EXT_WIDTH'(COUNT_MAX)) ?
                     COUNT_MAX : cnt_total[COUNT_WIDTH-1:0];
    if (sum_total[SUM_WIDTH] != sum_total[SUM_WIDTH-1]) begin
      acc_sum_next = sum_total[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      acc_sum_next = sum_total[SUM_WIDTH-1:0];
    end
    acc_sum_squares_next = sq_total[SQ_WIDTH] ? SQ_MAX : sq_total[SQ_WIDTH-1:0];
  end

  // Operand selection for the shared half-width multiplier.
  always_comb begin
    unique case (step)
      2'd0:    begin mul_a = mag[SUM_WIDTH-1:HALF_WIDTH]; mul_b = mag[SUM_WIDTH-1:HALF_WIDTH]; end
      2'd1:    begin mul_a = mag[SUM_WIDTH-1:HALF_WIDTH]; mul_b = mag[HALF_WIDTH-1:0]; end
      default: begin mul_a = mag[HALF_WIDTH-1:0];         mul_b = mag[HALF_WIDTH-1:0]; end
    endcase
  end

  assign quot_fits = !(|div_quotient[SQUARE_WIDTH-1:SQ_WIDTH]) &&
                     (div_quotient[SQ_WIDTH-1:0] <= acc_sum_squares);

  assign head_pop = (state == ST_IDLE) && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      acc_count       <= '0;
      acc_sum         <= '0;
      acc_sum_squares <= '0;
      div_start       <= 1'b0;
      sqrt_start      <= 1'b0;
      rpt_valid       <= 1'b0;
    end else begin
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
      if (rpt_valid && rpt_ready) begin
        rpt_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (head_valid) begin
            unique case (head.cmd)
              CMD_ACC: begin
                acc_count       <= acc_count_next;
                acc_sum         <= acc_sum_next;
                acc_sum_squares <= acc_sum_squares_next;
              end
              CMD_CLEAR: begin
                acc_count       <= '0;
                acc_sum         <= '0;
                acc_sum_squares <= '0;
              end
              CMD_REPORT: begin
                if (acc_count == '0) begin
                  result <= '0;
                  state  <= ST_HOLD;
                end else begin
                  mag   <= acc_sum[SUM_WIDTH-1] ? $unsigned(-acc_sum) : $unsigned(acc_sum);
                  step  <= 2'd0;
                  state <= ST_SQUARE;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SQUARE: begin
          step <= step + 2'd1;
          prod <= PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
          unique case (step)
            2'd0: square <= '0;
            2'd1: square <= SQUARE_WIDTH'(prod) << (2 * HALF_WIDTH);
            2'd2: square <= square + (SQUARE_WIDTH'(prod) << (HALF_WIDTH + 1));
            2'd3: begin
              div_dividend <= square + SQUARE_WIDTH'(prod);
              div_start    <= 1'b1;
              state        <= ST_DIV_Q;
            end
          endcase
        end
        ST_DIV_Q: begin
          if (div_done) begin
            if (quot_fits) begin
              div_dividend <= SQUARE_WIDTH'(acc_sum_squares - div_quotient[SQ_WIDTH-1:0]);
              div_start    <= 1'b1;
              state        <= ST_DIV_VAR;
            end else begin
              result <= '0;
              state  <= ST_HOLD;
            end
          end
        end
        ST_DIV_VAR: begin
          if (div_done) begin
            sqrt_radicand <= RADICAND_WIDTH'(div_quotient[SQ_WIDTH-1:0]);
            sqrt_start    <= 1'b1;
            state         <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (sqrt_done) begin
            result <= (|sqrt_root[ROOT_WIDTH-1:DEV_WIDTH]) ? '1 : sqrt_root[DEV_WIDTH-1:0];
            state  <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!rpt_valid || rpt_ready) begin
            rpt_valid         <= 1'b1;
            rpt.std_deviation <= result;
            rpt.sample_count  <= OUT_COUNT_WIDTH'(acc_count);
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  rsd_div #(
    .DIVIDEND_WIDTH (SQUARE_WIDTH),
    .DIVISOR_WIDTH  (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (acc_count),
    .quotient (div_quotient),
    .done     (div_done)
  );

  rsd_sqrt #(
    .RADICAND_WIDTH (RADICAND_WIDTH)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_radicand),
    .root     (sqrt_root),
    .done     (sqrt_done)
  );

endmodule

// File: sv/running_std_deviation.sv
// Channel   Direction  Handshake               Beat
// req       in         req_valid / req_ready   add, merge, clear or report request
// rpt       out        rpt_valid / rpt_ready   deviation and count, one per report
//
// Add, merge and clear beats are taken one per cycle while the back end is idle;
// each retires without leaving the idle state, so they stream at full rate
// through the two-entry queue. An empty-accumulator report goes straight to the
// output; otherwise it runs a four-step squaring of the sum, one or two 96-step
// passes of the shared restoring divider and, if both ran, a 32-step square root.
// Reset is synchronous and clears the accumulators, the queue and the output.
// Requests queue up behind a report; the front stalls only when the queue fills.
module running_std_deviation #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  rsd_pkg::in_item_t  req,
  output logic               rpt_valid,
  input  logic               rpt_ready,
  output rsd_pkg::out_item_t rpt
);
  import rsd_pkg::*;

  // The front end decodes each request beat, squares the sample and pushes
  // one accumulate, clear or report command into a small queue. The back end
  // owns the accumulators and the report sequencer, so a long report never
  // blocks the producer until the queue is full.
  logic     head_valid;
  logic     head_pop;
  q_entry_t head;

  rsd_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head       (head)
  );

  // The back end drains one command per cycle while idle; a report holds the
  // accumulators steady until its result sits in the output register.
  rsd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .rpt_valid  (rpt_valid),
    .rpt_ready  (rpt_ready),
    .rpt        (rpt)
  );

endmodule

// File: sv/rsd_checker.sv
module rsd_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input rsd_pkg::in_item_t  req,
  input logic               rpt_valid,
  input logic               rpt_ready,
  input rsd_pkg::out_item_t rpt
);
  import rsd_pkg::*;

  // Reports accepted but not yet delivered; the queue and back end hold a few.
  logic [2:0] pending;
  logic       rep_in;
  logic       rep_out;

  assign rep_in  = req_valid && req_ready && (req.req_type == REQ_REPORT);
  assign rep_out = rpt_valid && rpt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (rep_in && !rep_out) begin
      pending <= pending + 3'd1;
    end else if (rep_out && !rep_in) begin
      pending <= pending - 3'd1;
    end
  end

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !rpt_valid)
    else $error("result beat visible straight after reset");

  a_result_has_request: assert property (@(posedge clk) disable iff (rst)
    rpt_valid |-> (pending != 3'd0))
    else $error("result beat without an outstanding report request");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (rpt_valid && (rpt.sample_count == '0)) |-> (rpt.std_deviation == '0))
    else $error("non-zero deviation reported for an empty accumulator");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (rpt_valid && !rpt_ready) |=> (rpt_valid && $stable(rpt)))
    else $error("stalled result beat changed or vanished");

endmodule

bind running_std_deviation rsd_checker u_checker (.*);
